>>> rtl/ltra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltra_pkg
// Shared types and constants of the loss trend rate adapter.
// ----------------------------------------------------------------------------
package ltra_pkg;

   localparam int LOSS_W   = 32;
   localparam int RATE_W   = 32;
   localparam int FACTOR_W = 18;
   localparam int WINDOW_W = 7;
   localparam int CHANGE_W = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int PROD_W   = RATE_W + FACTOR_W;
   localparam int FRAC_W   = 16;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_DEPTH  = 4;
   localparam int RSP_PTR_W  = 2;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_INITIAL_RATE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DECAY_FACTOR    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INCREASE_FACTOR = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_LENGTH   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RATE_FLOOR      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_RATE_CEILING    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_ADAPT_ENABLE    = 3'd6;

   // register reset values
   localparam logic [RATE_W-1:0]   RST_INITIAL_RATE    = 32'd4294967;
   localparam logic [FACTOR_W-1:0] RST_DECAY_FACTOR    = 18'd62259;
   localparam logic [FACTOR_W-1:0] RST_INCREASE_FACTOR = 18'd68813;
   localparam logic [WINDOW_W-1:0] RST_WINDOW_LENGTH   = 7'd5;
   localparam logic [RATE_W-1:0]   RST_RATE_FLOOR      = 32'd4295;
   localparam logic [RATE_W-1:0]   RST_RATE_CEILING    = 32'd42949673;

   // rate change codes
   localparam logic [CHANGE_W-1:0] CHANGE_NONE    = 2'd0;
   localparam logic [CHANGE_W-1:0] CHANGE_RAISED  = 2'd1;
   localparam logic [CHANGE_W-1:0] CHANGE_LOWERED = 2'd2;

   typedef struct packed {
      logic                window_ready;
      logic [CHANGE_W-1:0] rate_change;
      logic [RATE_W-1:0]   learning_rate;
   } rsp_type;

endpackage

>>> rtl/loss_trend_rate_adapter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// loss_trend_rate_adapter_top
// Adapts a learning rate from the trend of two sliding windows of losses.
// ----------------------------------------------------------------------------
// One request carries a loss; one response returns the learning rate for that
// step. No request is accepted while stage 1 holds one: the rate update is
// a loop of two registers (the rate times factor product, then the saturate
// and clamp that writes the rate back), and the next request must see the
// written rate. The response passes the stage 1, stage 2 and stage 3
// registers into the output queue. Both history reads for a request (the entry
// leaving the newest window and the one leaving the older window) come from
// two read ports of the history memory at the accept edge, where the new loss
// is also written, so no forwarding is needed. A four-entry response queue
// lets requests keep flowing while responses wait. The history memory needs no
// clearing after reset; a fill count guards every read.
module loss_trend_rate_adapter_top #(
   parameter int HISTORY_DEPTH = 128,
   parameter int MAX_WINDOW    = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   // configuration port
   input  logic                            csr_we,
   input  logic [ltra_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ltra_pkg::CSR_DATA_W-1:0] csr_wdata,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ltra_pkg::REQ_DATA_W-1:0] req_tdata,  // [31:0] loss_sample
   // response channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [31:0] learning_rate, [33:32] rate_change, [34] window_ready, rest zero
   output logic [ltra_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import ltra_pkg::*;

   localparam int AW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CW    = AW + 1;
   localparam int WLIM  = (MAX_WINDOW < HISTORY_DEPTH / 2) ? MAX_WINDOW : HISTORY_DEPTH / 2;
   localparam int SUM_W = LOSS_W + $clog2(MAX_WINDOW) + 1;
   localparam int CMP_W = SUM_W + 7;
   localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);
   localparam logic [CW-1:0] WLIM_C  = CW'(WLIM);
   localparam logic [AW-1:0] LAST_IDX = AW'(HISTORY_DEPTH - 1);

   // configuration registers
   logic [RATE_W-1:0]   initial_rate_ff;
   logic [FACTOR_W-1:0] decay_factor_ff;
   logic [FACTOR_W-1:0] increase_factor_ff;
   logic [WINDOW_W-1:0] window_length_ff;
   logic [RATE_W-1:0]   rate_floor_ff;
   logic [RATE_W-1:0]   rate_ceiling_ff;
   logic                adapt_enable_ff;

   // adapter state
   logic [LOSS_W-1:0]   hist_mem [HISTORY_DEPTH];
   logic [AW-1:0]       write_index_ff, write_index_in;
   logic [CW-1:0]       fill_count_ff, fill_count_in;
   logic [SUM_W-1:0]    recent_sum_ff, recent_sum_in;
   logic [SUM_W-1:0]    older_sum_ff, older_sum_in;
   logic [RATE_W-1:0]   current_rate_ff, current_rate_in;

   // stage 1: history read data
   logic                s1_valid_ff;
   logic                s1_enable_ff, s1_compare_ff, s1_slide_ff;
   logic [LOSS_W-1:0]   s1_loss_ff;
   logic [LOSS_W-1:0]   s1_move_ff;
   logic [LOSS_W-1:0]   s1_leave_ff;
   // stage 2: decision
   logic                s2_valid_ff;
   logic                s2_ready_ff;
   logic [CHANGE_W-1:0] s2_change_ff, s2_change_in;
   // stage 3: product
   logic                s3_valid_ff;
   logic                s3_ready_ff;
   logic [CHANGE_W-1:0] s3_change_ff;
   logic [PROD_W-1:0]   s3_prod_ff;

   // response queue
   rsp_type              rsp_q [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] rsp_wr_ptr_ff, rsp_rd_ptr_ff;
   logic [RSP_PTR_W:0]   rsp_count_ff, rsp_count_in;
   logic [RSP_PTR_W:0]   occupancy;
   rsp_type              rsp_new;

   logic                req_accept, rsp_pop;
   logic [CW-1:0]       w_eff, w_twice;
   logic [CW-1:0]       addr_move_full, addr_leave_full;
   logic [AW-1:0]       addr_move, addr_leave;
   logic                compare_now, slide_now;
   logic [LOSS_W-1:0]   move_term, leave_term;
   logic [CMP_W-1:0]    recent_x100, older_x99, older_x101;
   logic [FACTOR_W-1:0] factor_sel;
   logic [PROD_W-FRAC_W-1:0] prod_shift;
   logic [RATE_W-1:0]   scaled_rate;
   logic                clear_req;

   // effective window: zero acts as one, large values saturate
   always_comb begin
      if (window_length_ff == '0) begin
         w_eff = CW'(1);
      end else if (32'(window_length_ff) >= 32'(WLIM)) begin
         w_eff = WLIM_C;
      end else begin
         w_eff = CW'(window_length_ff);
      end
      w_twice = CW'({w_eff, 1'b0});
   end

   // ring addresses n entries back from the write index
   always_comb begin
      addr_move_full  = CW'(write_index_ff) + DEPTH_C - w_eff;
      addr_leave_full = CW'(write_index_ff) + DEPTH_C - w_twice;
      if (addr_move_full >= DEPTH_C) begin
         addr_move_full = addr_move_full - DEPTH_C;
      end
      if (addr_leave_full >= DEPTH_C) begin
         addr_leave_full = addr_leave_full - DEPTH_C;
      end
      addr_move  = addr_move_full[AW-1:0];
      addr_leave = addr_leave_full[AW-1:0];
   end

   assign compare_now = adapt_enable_ff && (fill_count_ff >= w_twice);
   assign slide_now   = adapt_enable_ff && (fill_count_ff >= w_eff);

   // flow control: no request while stage 1 holds one, with room kept in the queue
   assign occupancy  = rsp_count_ff + (RSP_PTR_W+1)'(s2_valid_ff)
                       + (RSP_PTR_W+1)'(s3_valid_ff);
   assign req_tready = !s1_valid_ff && (occupancy < (RSP_PTR_W+1)'(RSP_DEPTH));
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = (rsp_count_ff != '0);
   assign rsp_pop    = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = RSP_DATA_W'(rsp_q[rsp_rd_ptr_ff]);

   assign clear_req = csr_we && ((csr_index == REG_INITIAL_RATE) ||
                                 (csr_index == REG_WINDOW_LENGTH));

   // history memory: new loss written at accept, both reads see the old data
   always_ff @(posedge clock) begin
      if (req_accept) begin
         if (adapt_enable_ff) begin
            hist_mem[write_index_ff] <= req_tdata[LOSS_W-1:0];
         end
         s1_move_ff  <= hist_mem[addr_move];
         s1_leave_ff <= hist_mem[addr_leave];
         s1_loss_ff  <= req_tdata[LOSS_W-1:0];
      end
   end

   // stage 1 to 2: window compare and sum update
   always_comb begin
      move_term   = s1_slide_ff ? s1_move_ff : '0;
      leave_term  = s1_compare_ff ? s1_leave_ff : '0;
      recent_x100 = CMP_W'(recent_sum_ff) * CMP_W'(100);
      older_x99   = CMP_W'(older_sum_ff) * CMP_W'(99);
      older_x101  = CMP_W'(older_sum_ff) * CMP_W'(101);
      s2_change_in = CHANGE_NONE;
      if (s1_compare_ff) begin
         if (recent_x100 < older_x99) begin
            s2_change_in = CHANGE_RAISED;
         end else if (recent_x100 > older_x101) begin
            s2_change_in = CHANGE_LOWERED;
         end
      end
      recent_sum_in = recent_sum_ff;
      older_sum_in  = older_sum_ff;
      if (s1_valid_ff && s1_enable_ff) begin
         recent_sum_in = recent_sum_ff - SUM_W'(move_term) + SUM_W'(s1_loss_ff);
         older_sum_in  = older_sum_ff + SUM_W'(move_term) - SUM_W'(leave_term);
      end
   end

   assign factor_sel = (s2_change_ff == CHANGE_RAISED) ? increase_factor_ff : decay_factor_ff;

   // stage 3: saturate, clamp and write back the rate
   always_comb begin
      prod_shift = s3_prod_ff[PROD_W-1:FRAC_W];
      if (prod_shift[PROD_W-FRAC_W-1:RATE_W] != '0) begin
         scaled_rate = '1;
      end else begin
         scaled_rate = prod_shift[RATE_W-1:0];
      end
      current_rate_in = current_rate_ff;
      if (s3_valid_ff) begin
         case (s3_change_ff)
            CHANGE_RAISED: begin
               current_rate_in = (scaled_rate < rate_ceiling_ff) ? scaled_rate
                                                                  : rate_ceiling_ff;
            end
            CHANGE_LOWERED: begin
               current_rate_in = (scaled_rate > rate_floor_ff) ? scaled_rate
                                                                : rate_floor_ff;
            end
            default: begin
               current_rate_in = current_rate_ff;
            end
         endcase
      end
      rsp_new.learning_rate = current_rate_in;
      rsp_new.rate_change   = s3_change_ff;
      rsp_new.window_ready  = s3_ready_ff;
   end

   // ring index and fill count advance on every recorded loss
   always_comb begin
      write_index_in = write_index_ff;
      fill_count_in  = fill_count_ff;
      if (req_accept && adapt_enable_ff) begin
         write_index_in = (write_index_ff == LAST_IDX) ? '0 : write_index_ff + AW'(1);
         if (fill_count_ff < DEPTH_C) begin
            fill_count_in = fill_count_ff + CW'(1);
         end
      end
      rsp_count_in = rsp_count_ff + (RSP_PTR_W+1)'(s3_valid_ff)
                     - (RSP_PTR_W+1)'(rsp_pop);
   end

   // payload of the pipeline stages
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_enable_ff  <= adapt_enable_ff;
         s1_compare_ff <= compare_now;
         s1_slide_ff   <= slide_now;
      end
      s2_change_ff <= s2_change_in;
      s2_ready_ff  <= s1_compare_ff;
      s3_change_ff <= s2_change_ff;
      s3_ready_ff  <= s2_ready_ff;
      s3_prod_ff   <= PROD_W'(current_rate_ff) * PROD_W'(factor_sel);
      if (s3_valid_ff) begin
         rsp_q[rsp_wr_ptr_ff] <= rsp_new;
      end
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         initial_rate_ff    <= RST_INITIAL_RATE;
         decay_factor_ff    <= RST_DECAY_FACTOR;
         increase_factor_ff <= RST_INCREASE_FACTOR;
         window_length_ff   <= RST_WINDOW_LENGTH;
         rate_floor_ff      <= RST_RATE_FLOOR;
         rate_ceiling_ff    <= RST_RATE_CEILING;
         adapt_enable_ff    <= 1'b1;
         write_index_ff     <= '0;
         fill_count_ff      <= '0;
         recent_sum_ff      <= '0;
         older_sum_ff       <= '0;
         current_rate_ff    <= RST_INITIAL_RATE;
         s1_valid_ff        <= 1'b0;
         s2_valid_ff        <= 1'b0;
         s3_valid_ff        <= 1'b0;
         rsp_wr_ptr_ff      <= '0;
         rsp_rd_ptr_ff      <= '0;
         rsp_count_ff       <= '0;
      end else begin
         s1_valid_ff  <= req_accept;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_count_ff <= rsp_count_in;
         if (s3_valid_ff) begin
            rsp_wr_ptr_ff <= rsp_wr_ptr_ff + RSP_PTR_W'(1);
         end
         if (rsp_pop) begin
            rsp_rd_ptr_ff <= rsp_rd_ptr_ff + RSP_PTR_W'(1);
         end
         if (csr_we) begin
            case (csr_index)
               REG_INITIAL_RATE:    initial_rate_ff    <= csr_wdata[RATE_W-1:0];
               REG_DECAY_FACTOR:    decay_factor_ff    <= csr_wdata[FACTOR_W-1:0];
               REG_INCREASE_FACTOR: increase_factor_ff <= csr_wdata[FACTOR_W-1:0];
               REG_WINDOW_LENGTH:   window_length_ff   <= csr_wdata[WINDOW_W-1:0];
               REG_RATE_FLOOR:      rate_floor_ff      <= csr_wdata[RATE_W-1:0];
               REG_RATE_CEILING:    rate_ceiling_ff    <= csr_wdata[RATE_W-1:0];
               REG_ADAPT_ENABLE:    adapt_enable_ff    <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         if (clear_req) begin
            // new window or start rate: forget the history
            write_index_ff  <= '0;
            fill_count_ff   <= '0;
            recent_sum_ff   <= '0;
            older_sum_ff    <= '0;
            current_rate_ff <= (csr_index == REG_INITIAL_RATE) ? csr_wdata[RATE_W-1:0]
                                                                : initial_rate_ff;
         end else begin
            write_index_ff  <= write_index_in;
            fill_count_ff   <= fill_count_in;
            recent_sum_ff   <= recent_sum_in;
            older_sum_ff    <= older_sum_in;
            current_rate_ff <= current_rate_in;
         end
      end
   end

endmodule

>>> sim/loss_trend_rate_adapter_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// loss_trend_rate_adapter_top_tb
// Self-checking bench for the loss trend rate adapter. A directed table covers
// reset values, factor and clamp extremes, pass-through and window limits,
// then random phases reprogram the registers and stream loss trends. Every
// response is checked field by field against a local rate model or a pinned table value.
// ----------------------------------------------------------------------------
module loss_trend_rate_adapter_top_tb;
   import ltra_pkg::*;

   localparam int HISTORY_DEPTH = 128;
   localparam int MAX_WINDOW    = 64;
   localparam int RANDOM_LOSSES = 900;
   localparam int SETTLE_CYCLES = 8;
   localparam int SHOW_LIMIT    = 10;
   localparam int WANT_DEPTH    = 256;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;

   typedef enum logic {ROW_LOSS, ROW_REG} row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] reg_index;
      logic [31:0]          value;
      logic                 pinned;
      rsp_type              want;
   } row_type;

   typedef enum int {SINK_OPEN, SINK_COIN, SINK_SLOW, SINK_BURSTY} sink_mode_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // [31:0] loss_sample
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [31:0] learning_rate, [33:32] rate_change, [34] window_ready, rest zero
   logic [RSP_DATA_W-1:0] rsp_tdata;

   loss_trend_rate_adapter_top #(
      .HISTORY_DEPTH(HISTORY_DEPTH),
      .MAX_WINDOW   (MAX_WINDOW)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // ---------------------------------------------------------------- rate model
   logic [RATE_W-1:0]   cfg_initial_rate;
   logic [FACTOR_W-1:0] cfg_decay;
   logic [FACTOR_W-1:0] cfg_increase;
   logic [WINDOW_W-1:0] cfg_window;
   logic [RATE_W-1:0]   cfg_floor;
   logic [RATE_W-1:0]   cfg_ceiling;
   logic                cfg_adapt;

   logic [LOSS_W-1:0]   hist_loss [HISTORY_DEPTH];
   int                  hist_wr;
   int                  hist_fill;
   logic [63:0]         newest_sum;
   logic [63:0]         prior_sum;
   logic [RATE_W-1:0]   model_rate;

   // expected responses in request order
   rsp_type             want_ring [WANT_DEPTH];
   int unsigned         want_wr = 0;
   int unsigned         want_rd = 0;
   int unsigned         fail_count;
   int unsigned         shown_count;
   int                  burst_left;

   function automatic int unsigned want_level();
      return want_wr - want_rd;
   endfunction

   function automatic int window_span();
      int w;
      w = cfg_window;
      if (w == 0) w = 1;
      if (w > MAX_WINDOW) w = MAX_WINDOW;
      if (w > HISTORY_DEPTH / 2) w = HISTORY_DEPTH / 2;
      return w;
   endfunction

   function automatic void restart_history();
      hist_wr    = 0;
      hist_fill  = 0;
      newest_sum = '0;
      prior_sum  = '0;
      model_rate = cfg_initial_rate;
   endfunction

   function automatic void reset_rate_model();
      cfg_initial_rate = RST_INITIAL_RATE;
      cfg_decay        = RST_DECAY_FACTOR;
      cfg_increase     = RST_INCREASE_FACTOR;
      cfg_window       = RST_WINDOW_LENGTH;
      cfg_floor        = RST_RATE_FLOOR;
      cfg_ceiling      = RST_RATE_CEILING;
      cfg_adapt        = 1'b1;
      restart_history();
   endfunction

   function automatic void apply_reg_write(logic [CSR_IDX_W-1:0] idx,
                                           logic [CSR_DATA_W-1:0] data);
      case (idx)
         REG_INITIAL_RATE: begin
            cfg_initial_rate = data;
            restart_history();
         end
         REG_DECAY_FACTOR:    cfg_decay    = data[FACTOR_W-1:0];
         REG_INCREASE_FACTOR: cfg_increase = data[FACTOR_W-1:0];
         REG_WINDOW_LENGTH: begin
            cfg_window = data[WINDOW_W-1:0];
            restart_history();
         end
         REG_RATE_FLOOR:   cfg_floor   = data;
         REG_RATE_CEILING: cfg_ceiling = data;
         REG_ADAPT_ENABLE: cfg_adapt   = data[0];
         default: ;
      endcase
   endfunction

   // Q0.32 rate times Q2.16 factor, truncated, saturated to 32 bits
   function automatic logic [RATE_W-1:0] scaled_rate(logic [RATE_W-1:0] rate,
                                                     logic [FACTOR_W-1:0] factor);
      logic [63:0] prod;
      prod = ({32'b0, rate} * {46'b0, factor}) >> FRAC_W;
      return (prod > 64'hFFFF_FFFF) ? '1 : prod[RATE_W-1:0];
   endfunction

   function automatic rsp_type step_rate_model(logic [LOSS_W-1:0] loss);
      rsp_type           r;
      int                w;
      logic [RATE_W-1:0] v;
      logic [LOSS_W-1:0] moved;
      w               = window_span();
      r.rate_change   = CHANGE_NONE;
      r.window_ready  = 1'b0;
      if (cfg_adapt) begin
         // trend is judged on the history before this loss goes in
         if (hist_fill >= 2 * w) begin
            r.window_ready = 1'b1;
            if (newest_sum * 100 < prior_sum * 99) begin
               v = scaled_rate(model_rate, cfg_increase);
               model_rate    = (v < cfg_ceiling) ? v : cfg_ceiling;
               r.rate_change = CHANGE_RAISED;
            end else if (newest_sum * 100 > prior_sum * 101) begin
               v = scaled_rate(model_rate, cfg_decay);
               model_rate    = (v > cfg_floor) ? v : cfg_floor;
               r.rate_change = CHANGE_LOWERED;
            end
         end
         if (hist_fill >= w) begin
            moved      = hist_loss[(hist_wr + HISTORY_DEPTH - w) % HISTORY_DEPTH];
            newest_sum = newest_sum - moved;
            prior_sum  = prior_sum + moved;
         end
         if (hist_fill >= 2 * w)
            prior_sum = prior_sum - hist_loss[(hist_wr + HISTORY_DEPTH - 2 * w) % HISTORY_DEPTH];
         newest_sum = newest_sum + loss;
         hist_loss[hist_wr] = loss;
         hist_wr = (hist_wr + 1) % HISTORY_DEPTH;
         if (hist_fill < HISTORY_DEPTH) hist_fill++;
      end
      r.learning_rate = model_rate;
      return r;
   endfunction

   // ---------------------------------------------------------------- drivers
   task automatic push_loss(input logic [LOSS_W-1:0] loss, input bit pinned,
                            input rsp_type pinned_rsp);
      int      gap;
      rsp_type predicted;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
      burst_left--;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= loss;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = step_rate_model(loss);
      want_ring[want_wr % WANT_DEPTH] = pinned ? pinned_rsp : predicted;
      want_wr++;
   endtask

   // hold off requests until every response is back and the pipe has drained
   task automatic wait_block_idle();
      req_tvalid <= 1'b0;
      while (want_level() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      apply_reg_write(idx, data);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // new register values for a phase; upper bits of narrow registers get junk
   task automatic retune_regs(input bit every_reg);
      logic [31:0] v;
      int          pick;
      if (every_reg || $urandom_range(0, 3) == 0) begin
         pick = $urandom_range(0, 3);
         v = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom();
         write_reg(REG_INITIAL_RATE, v);
      end
      if (every_reg || $urandom_range(0, 1) == 0) begin
         pick = $urandom_range(0, 5);
         v = (pick == 0) ? 32'h0 : (pick == 1) ? 32'h3FFFF :
             (pick == 2) ? $urandom() : $urandom_range(0, 65535);
         write_reg(REG_DECAY_FACTOR,
                   ($urandom() & 32'hFFFC_0000) | {14'b0, v[FACTOR_W-1:0]});
      end
      if (every_reg || $urandom_range(0, 1) == 0) begin
         pick = $urandom_range(0, 5);
         v = (pick == 0) ? 32'h0 : (pick == 1) ? 32'h3FFFF :
             (pick == 2) ? $urandom() : $urandom_range(65536, 131071);
         write_reg(REG_INCREASE_FACTOR,
                   ($urandom() & 32'hFFFC_0000) | {14'b0, v[FACTOR_W-1:0]});
      end
      if (every_reg || $urandom_range(0, 2) == 0) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0: v = 0;
            1: v = 1;
            2: v = 2;
            3: v = 3;
            4, 5: v = $urandom_range(4, 16);
            6: v = $urandom_range(17, 63);
            7: v = 64;
            8: v = $urandom_range(65, 127);
            default: v = 5;
         endcase
         write_reg(REG_WINDOW_LENGTH, ($urandom() & 32'hFFFF_FF80) | v);
      end
      if (every_reg || $urandom_range(0, 2) == 0) begin
         pick = $urandom_range(0, 5);
         v = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF :
             (pick == 2) ? $urandom() : ($urandom() >> $urandom_range(4, 20));
         write_reg(REG_RATE_FLOOR, v);
      end
      if (every_reg || $urandom_range(0, 2) == 0) begin
         pick = $urandom_range(0, 5);
         v = (pick == 0) ? 32'h0 : (pick <= 2) ? 32'hFFFF_FFFF : $urandom();
         write_reg(REG_RATE_CEILING, v);
      end
      if (every_reg || $urandom_range(0, 2) == 0) begin
         v = ($urandom() & 32'hFFFF_FFFE) | ($urandom_range(0, 5) != 0);
         write_reg(REG_ADAPT_ENABLE, v);
      end
   endtask

   // a run of losses shaped as a trend, a plateau, jitter, a square wave or noise
   task automatic run_loss_phase(input int count);
      int          mode;
      int          toggle_len;
      longint      base;
      longint      level_b;
      longint      drift;
      longint      amp;
      longint      val;
      logic [31:0] loss;
      mode       = $urandom_range(0, 4);
      base       = longint'($urandom() >> $urandom_range(0, 24));
      level_b    = longint'($urandom() >> $urandom_range(0, 24));
      drift      = (base >> $urandom_range(4, 9)) + 1;
      if ($urandom_range(0, 1) == 0) drift = -drift;
      toggle_len = $urandom_range(1, 20);
      for (int n = 0; n < count; n++) begin
         case (mode)
            0: val = longint'($urandom());
            1: val = base;
            2: begin
               base = base + drift;
               if (base < 0) base = 0;
               if (base > 64'hFFFF_FFFF) base = 64'hFFFF_FFFF;
               val = base;
            end
            3: begin
               amp = base >> 8;
               val = base - amp + longint'($urandom_range(0, 32'(2 * amp)));
            end
            default: val = ((n / toggle_len) % 2 == 1) ? level_b : base;
         endcase
         if (val > 64'hFFFF_FFFF) val = 64'hFFFF_FFFF;
         loss = val[31:0];
         if ($urandom_range(0, 11) == 0) loss = $urandom();
         push_loss(loss, 1'b0, '0);
      end
   endtask

   // ---------------------------------------------------------------- directed table
   localparam int PLAN_LEN = 31;
   row_type plan [PLAN_LEN] = '{
      '{ROW_LOSS, '0, 32'h0000_0000, 1'b1, '{1'b0, CHANGE_NONE, RST_INITIAL_RATE}},
      '{ROW_LOSS, '0, 32'hFFFF_FFFF, 1'b1, '{1'b0, CHANGE_NONE, RST_INITIAL_RATE}},
      '{ROW_REG, REG_WINDOW_LENGTH,   32'd1,         1'b0, '0},
      '{ROW_REG, REG_INITIAL_RATE,    32'hFFFF_FFFF, 1'b0, '0},
      '{ROW_REG, REG_INCREASE_FACTOR, 32'h0003_FFFF, 1'b0, '0},
      '{ROW_REG, REG_RATE_CEILING,    32'hFFFF_FFFF, 1'b0, '0},
      '{ROW_LOSS, '0, 32'h0000_1000, 1'b1, '{1'b0, CHANGE_NONE, 32'hFFFF_FFFF}},
      '{ROW_LOSS, '0, 32'h0000_2000, 1'b1, '{1'b0, CHANGE_NONE, 32'hFFFF_FFFF}},
      // worsening loss, default decay
      '{ROW_LOSS, '0, 32'h0000_0800, 1'b0, '0},
      // improving, product saturates
      '{ROW_LOSS, '0, 32'h0000_0800, 1'b1, '{1'b1, CHANGE_RAISED, 32'hFFFF_FFFF}},
      '{ROW_LOSS, '0, 32'hFFFF_FFFF, 1'b1, '{1'b1, CHANGE_NONE, 32'hFFFF_FFFF}},
      '{ROW_REG, REG_DECAY_FACTOR,    32'd0,         1'b0, '0},
      '{ROW_LOSS, '0, 32'h0000_0000, 1'b1, '{1'b1, CHANGE_LOWERED, RST_RATE_FLOOR}},
      '{ROW_LOSS, '0, 32'h0001_0000, 1'b0, '0},
      '{ROW_REG, REG_RATE_FLOOR,      32'hFFFF_FFFF, 1'b0, '0},
      '{ROW_REG, REG_DECAY_FACTOR,    32'h0003_FFFF, 1'b0, '0},
      // floor above the scaled rate still wins
      '{ROW_LOSS, '0, 32'h0000_8000, 1'b1, '{1'b1, CHANGE_LOWERED, 32'hFFFF_FFFF}},
      '{ROW_REG, REG_RATE_CEILING,    32'd0,         1'b0, '0},
      '{ROW_LOSS, '0, 32'h0000_8000, 1'b1, '{1'b1, CHANGE_RAISED, 32'h0}},
      '{ROW_LOSS, '0, 32'h0000_8000, 1'b1, '{1'b1, CHANGE_NONE, 32'h0}},
      '{ROW_REG, REG_ADAPT_ENABLE,    32'd0,         1'b0, '0},
      '{ROW_LOSS, '0, 32'h0000_0001, 1'b1, '{1'b0, CHANGE_NONE, 32'h0}},
      '{ROW_LOSS, '0, 32'hDEAD_BEEF, 1'b1, '{1'b0, CHANGE_NONE, 32'h0}},
      '{ROW_REG, REG_ADAPT_ENABLE,    32'd1,         1'b0, '0},
      // history untouched while pass-through
      '{ROW_LOSS, '0, 32'h0000_0001, 1'b1, '{1'b1, CHANGE_NONE, 32'h0}},
      // zero window acts as one, and reloads the rate
      '{ROW_REG, REG_WINDOW_LENGTH,   32'd0,         1'b0, '0},
      '{ROW_LOSS, '0, 32'h0000_0005, 1'b1, '{1'b0, CHANGE_NONE, 32'hFFFF_FFFF}},
      '{ROW_LOSS, '0, 32'h0000_0005, 1'b1, '{1'b0, CHANGE_NONE, 32'hFFFF_FFFF}},
      '{ROW_LOSS, '0, 32'h0000_0005, 1'b1, '{1'b1, CHANGE_NONE, 32'hFFFF_FFFF}},
      '{ROW_REG, REG_UNUSED,          32'hFFFF_FFFF, 1'b0, '0},
      '{ROW_REG, REG_WINDOW_LENGTH,   32'd127,       1'b0, '0}
   };

   // ---------------------------------------------------------------- main flow
   initial begin : stimulus
      int random_sent;
      int phase_len;
      bit first_phase;
      fail_count  = 0;
      shown_count = 0;
      burst_left  = 0;
      reset_rate_model();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < PLAN_LEN; i++) begin
         if (plan[i].kind == ROW_REG) begin
            wait_block_idle();
            write_reg(plan[i].reg_index, plan[i].value);
         end else begin
            push_loss(plan[i].value, plan[i].pinned, plan[i].want);
         end
      end

      random_sent = 0;
      first_phase = 1'b1;
      while (random_sent < RANDOM_LOSSES) begin
         wait_block_idle();
         retune_regs(first_phase);
         first_phase = 1'b0;
         if (!cfg_adapt)
            phase_len = $urandom_range(10, 30);
         else if (window_span() > 16)
            phase_len = $urandom_range(140, 220);
         else
            phase_len = $urandom_range(20, 90);
         run_loss_phase(phase_len);
         random_sent += phase_len;
      end

      wait_block_idle();
      if (fail_count == 0 && want_level() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // ---------------------------------------------------------------- response side
   sink_mode_type sink_mode = SINK_OPEN;
   int unsigned   sink_mode_left = 0;
   int unsigned   sink_hold = 0;
   logic [1:0]    sink_phase = '0;

   always @(posedge clock) begin
      sink_phase <= sink_phase + 2'd1;
      if (sink_mode_left == 0) begin
         sink_mode      <= sink_mode_type'($urandom_range(0, 3));
         sink_mode_left <= $urandom_range(50, 300);
      end else begin
         sink_mode_left <= sink_mode_left - 1;
      end
      case (sink_mode)
         SINK_OPEN: rsp_tready <= 1'b1;
         SINK_COIN: rsp_tready <= 1'($urandom_range(0, 1));
         SINK_SLOW: rsp_tready <= (sink_phase == 2'd0);
         default: begin
            if (sink_hold != 0) begin
               rsp_tready <= 1'b0;
               sink_hold  <= sink_hold - 1;
            end else begin
               rsp_tready <= 1'b1;
               if ($urandom_range(0, 5) == 0) sink_hold <= $urandom_range(1, 24);
            end
         end
      endcase
   end

   always @(posedge clock) begin : check_rsp
      rsp_type got_rsp;
      rsp_type want_rsp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_rsp = rsp_type'(rsp_tdata[$bits(rsp_type)-1:0]);
         if (want_level() == 0) begin
            fail_count++;
            if (shown_count < SHOW_LIMIT) begin
               shown_count++;
               $display("unexpected response: rate %h change %0d ready %0b",
                        got_rsp.learning_rate, got_rsp.rate_change, got_rsp.window_ready);
            end
         end else begin
            want_rsp = want_ring[want_rd % WANT_DEPTH];
            want_rd++;
            if (got_rsp.learning_rate !== want_rsp.learning_rate ||
                got_rsp.rate_change   !== want_rsp.rate_change ||
                got_rsp.window_ready  !== want_rsp.window_ready) begin
               fail_count++;
               if (shown_count < SHOW_LIMIT) begin
                  shown_count++;
                  $display("rate mismatch at %0t: expected rate %h change %0d ready %0b,",
                           $realtime, want_rsp.learning_rate, want_rsp.rate_change,
                           want_rsp.window_ready);
                  $display("   got rate %h change %0d ready %0b",
                           got_rsp.learning_rate, got_rsp.rate_change,
                           got_rsp.window_ready);
               end
            end
         end
      end
   end

endmodule
